// ----- src/piecewise_linear_curve_lookup_macros.svh -----
// Assertion macros for the piecewise-linear curve lookup checker.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/plcl_pkg.sv -----
// Shared types and constants for the piecewise-linear curve lookup.
package plcl_pkg;
    localparam logic [1:0] OUT_INTERP   = 2'd0;
    localparam logic [1:0] OUT_FALLBACK = 2'd1;
    localparam logic [1:0] OUT_BELOW    = 2'd2;
    localparam logic [1:0] OUT_ABOVE    = 2'd3;
    localparam logic       ACT_LOAD     = 1'b0;
    localparam logic       ACT_SAMPLE   = 1'b1;
    localparam logic       REG_POINTS   = 1'b0;
    localparam logic       REG_FALLBACK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [3:0]        point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_x;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         outcome;
    } t_out;

    // Token passed down the cell chain during a search.
    typedef struct packed {
        logic               active;
        logic               found;
        logic signed [31:0] q;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
    } t_tok;
endpackage

// ----- src/plcl_cell.sv -----
// One breakpoint cell: stores (x, y) and checks the passing search token.
module plcl_cell (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic               i_en,
    input  logic               i_first,
    input  plcl_pkg::t_tok     i_tok,
    output plcl_pkg::t_tok     o_tok
);
    import plcl_pkg::*;

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    t_tok               r_tok;
    t_tok               n_tok;

    // Breakpoint storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    // Match when the query lies at or below this point; previous point kept in token
    always_comb begin
        n_tok = i_tok;
        if (i_tok.active && !i_tok.found && i_en && !i_first && (i_tok.q <= r_x)) begin
            n_tok.found = 1'b1;
            n_tok.bx    = r_x;
            n_tok.by    = r_y;
        end
        if (!n_tok.found) begin
            n_tok.ax = r_x;
            n_tok.ay = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;
endmodule

// ----- src/plcl_interp.sv -----
// Sequential interpolator: restoring divide for t, then multiply and saturate.
module plcl_interp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_ax,
    input  logic signed [31:0] i_ay,
    input  logic signed [31:0] i_bx,
    input  logic signed [31:0] i_by,
    input  logic signed [31:0] i_q,
    output logic               o_done,
    output logic signed [31:0] o_value
);
    import plcl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]         r_st;
    logic [5:0]         r_cnt;
    logic [32:0]        r_span;
    logic [33:0]        r_rem;
    logic [48:0]        r_num;
    logic [16:0]        r_t;
    logic signed [32:0] r_dy;
    logic signed [31:0] r_ay;
    logic signed [50:0] r_prod;
    logic signed [31:0] r_val;

    logic signed [32:0] span_w;
    logic signed [32:0] off_w;
    logic [32:0]        off_c;
    logic [33:0]        rem_sh;
    logic signed [34:0] res_w;

    assign span_w = 33'(i_bx) - 33'(i_ax);
    assign off_w  = 33'(i_q) - 33'(i_ax);

    // Clamp offset into [0, span]
    always_comb begin
        if (off_w < 0)                    off_c = 33'd0;
        else if (off_w > span_w)          off_c = 33'(span_w);
        else                              off_c = 33'(off_w);
    end

    assign rem_sh = {r_rem[32:0], r_num[48]};
    // ay + floor(prod / 65536), arithmetic shift floors toward minus infinity
    assign res_w  = 35'(r_ay) + 35'(r_prod >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            unique case (r_st)
                ST_IDLE: if (i_start) r_st <= (span_w > 0) ? ST_DIV : ST_MUL;
                ST_DIV:  if (r_cnt == 6'd48) r_st <= ST_MUL;
                ST_MUL:  r_st <= ST_OUT;
                ST_OUT:  r_st <= ST_IDLE;
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_span <= 33'(span_w);
                r_num  <= {off_c[32:0], 16'd0};
                r_rem  <= 34'd0;
                r_cnt  <= 6'd0;
                r_t    <= 17'd0;
                r_dy   <= 33'(i_by) - 33'(i_ay);
                r_ay   <= i_ay;
            end
            ST_DIV: begin
                r_num <= {r_num[47:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (rem_sh >= {1'b0, r_span}) begin
                    r_rem <= rem_sh - {1'b0, r_span};
                    r_t   <= {r_t[15:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_t   <= {r_t[15:0], 1'b0};
                end
            end
            ST_MUL: r_prod <= 51'(r_dy) * $signed({1'b0, r_t});
            ST_OUT: begin
                if (res_w > 35'sd2147483647)       r_val <= 32'sh7fffffff;
                else if (res_w < -35'sd2147483648) r_val <= 32'sh80000000;
                else                               r_val <= res_w[31:0];
            end
            default: ;
        endcase
    end

    assign o_done  = (r_st == ST_IDLE);
    assign o_value = r_val;
endmodule

// ----- src/piecewise_linear_curve_lookup.sv -----
// Piecewise-linear lookup: a load gives no result. A sample shows its result in the
// cycle after the transfer with no points in use; when it clamps to an end point,
// the first walk state settles it; else it passes a walk of the MAX_POINTS cells,
// 49-step divide, multiply, saturate, output. One item at a time: input stalls
// while busy or while a result waits stalled. Synchronous active-low reset clears
// control and configuration registers; breakpoint contents are undefined until loaded.
module piecewise_linear_curve_lookup #(
    parameter int MAX_POINTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  plcl_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output plcl_pkg::t_out  o_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import plcl_pkg::*;

    localparam int IW = $clog2(MAX_POINTS + 1);
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int AW = $clog2(MAX_POINTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_INT  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [4:0]         r_points;
    logic signed [31:0] r_fallback;
    logic [2:0]         r_st;
    logic [CW-1:0]      r_cnt;
    logic [IW-1:0]      r_n;
    logic signed [31:0] r_q;
    logic               r_ov;
    t_out               r_out;
    logic signed [31:0] r_first_x, r_first_y, r_last_x, r_last_y;

    t_tok               tok [MAX_POINTS+1];
    t_tok               tok_head;
    logic               load_ok;
    logic               acc;
    logic [IW-1:0]      n_eff;
    logic               int_done;
    logic signed [31:0] int_val;
    logic               int_start;
    t_tok               tok_end;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE) || (r_ov && i_stall);
    assign load_ok = acc && (i_data.action == ACT_LOAD)
                     && ((IW+1)'(i_data.point_index) < (IW+1)'(MAX_POINTS));
    assign n_eff   = (int'(r_points) > MAX_POINTS) ? IW'(MAX_POINTS) : IW'(r_points);

    // Head token enters the chain at the start of a sample
    always_comb begin
        tok_head        = '0;
        tok_head.active = (r_st == S_WALK) && (r_cnt == '0);
        tok_head.q      = r_q;
    end
    assign tok[0] = tok_head;

    // Cell chain; cell i is only searched if i < n
    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        plcl_cell u_cell (
            .i_clk   (i_clk),
            .i_we    (load_ok && (int'(i_data.point_index) == g)),
            .i_x     (i_data.point_x),
            .i_y     (i_data.point_y),
            .i_en    (int'(r_n) > g),
            .i_first (g == 0),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end
    assign tok_end = tok[MAX_POINTS];

    // Endpoint copies used for the clamp checks
    logic [IW-1:0] last_idx;
    assign last_idx = n_eff - IW'(1);
    logic signed [31:0] sh_x [MAX_POINTS];
    logic signed [31:0] sh_y [MAX_POINTS];
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            sh_x[AW'(i_data.point_index)] <= i_data.point_x;
            sh_y[AW'(i_data.point_index)] <= i_data.point_y;
        end
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points   <= 5'd0;
            r_fallback <= 32'sd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_POINTS) r_points <= i_cfg_data[4:0];
            else                           r_fallback <= i_cfg_data;
        end
    end

    // Interpolator takes the token in the cycle it leaves the last cell
    assign int_start = (r_st == S_WALK) && (r_cnt == CW'(MAX_POINTS)) && tok_end.found;

    plcl_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (int_start),
        .i_ax    (tok_end.ax),
        .i_ay    (tok_end.ay),
        .i_bx    (tok_end.bx),
        .i_by    (tok_end.by),
        .i_q     (r_q),
        .o_done  (int_done),
        .o_value (int_val)
    );

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (acc && i_data.action == ACT_SAMPLE) begin
                        r_q   <= i_data.query_x;
                        r_n   <= n_eff;
                        if (n_eff == '0) begin
                            r_out <= '{value: r_fallback, outcome: OUT_FALLBACK};
                            r_ov  <= 1'b1;
                        end else begin
                            r_first_x <= sh_x[0];
                            r_first_y <= sh_y[0];
                            r_last_x  <= sh_x[AW'(last_idx)];
                            r_last_y  <= sh_y[AW'(last_idx)];
                            r_cnt <= '0;
                            r_st  <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (r_cnt == '0 && r_q <= r_first_x) begin
                        r_out <= '{value: r_first_y, outcome: OUT_BELOW};
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else if (r_cnt == '0 && r_q >= r_last_x) begin
                        r_out <= '{value: r_last_y, outcome: OUT_ABOVE};
                        r_ov  <= 1'b1;
                        r_st  <= S_IDLE;
                    end else if (r_cnt == CW'(MAX_POINTS)) begin
                        if (tok_end.found) begin
                            r_st <= S_INT;
                        end else begin
                            r_out <= '{value: r_last_y, outcome: OUT_ABOVE};
                            r_ov  <= 1'b1;
                            r_st  <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_INT:  r_st <= S_WAIT;
                S_WAIT: if (int_done) r_st <= S_OUT;
                S_OUT: begin
                    r_out <= '{value: int_val, outcome: OUT_INTERP};
                    r_ov  <= 1'b1;
                    r_st  <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

// ----- src/plcl_checker.sv -----
// Port-level checker for the piecewise-linear curve lookup, with its bind.
`include "piecewise_linear_curve_lookup_macros.svh"
module plcl_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_stall,
    input plcl_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_stall,
    input plcl_pkg::t_out o_data
);
    import plcl_pkg::*;
    // Stalled result holds
    `PLC_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    // A load never produces a result in the next cycle
    `PLC_ASSERT_NXT(a_load, i_clk, i_rst_n, i_valid && !o_stall && i_data.action == ACT_LOAD && !(o_valid && i_stall), !o_valid)
    // A stalled result blocks the input
    `PLC_ASSERT_IMP(a_block, i_clk, i_rst_n, o_valid && i_stall, o_stall)
endmodule

bind piecewise_linear_curve_lookup plcl_checker u_plcl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
